// ===== design/mt19937_byte_stream_cipher_defines.svh =====
// Assertion macros for the MT19937 byte stream cipher.
// Used by the top level only; empty when SYNTH is defined.
`ifndef MT19937_BYTE_STREAM_CIPHER_DEFINES_SVH
`define MT19937_BYTE_STREAM_CIPHER_DEFINES_SVH
`ifndef SYNTH
`define MBSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsc assertion failed");
`define MBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsc assertion failed");
`else
`define MBSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/mbsc_pkg.sv =====
// Package for the MT19937 byte stream cipher: constants, types and helper functions.
// No dependencies.
`timescale 1ns / 1ps
package mbsc_pkg;

    localparam int unsigned WordCount = 624;
    localparam int unsigned IdxW      = 10;

    localparam logic [IdxW-1:0] IdxLast  = IdxW'(WordCount - 1);
    localparam logic [IdxW-1:0] ShiftFwd = IdxW'(397);
    localparam logic [IdxW-1:0] ShiftBck = IdxW'(WordCount - 397);

    localparam logic [31:0] MatrixA   = 32'h9908_B0DF;
    localparam logic [31:0] UpperMask = 32'h8000_0000;
    localparam logic [31:0] LowerMask = 32'h7FFF_FFFF;
    localparam logic [31:0] InitMult  = 32'd1812433253;
    localparam logic [31:0] TemperB   = 32'h9D2C_5680;
    localparam logic [31:0] TemperC   = 32'hEFC6_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_INIT,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_DRAW_RD,
        ST_DRAW_TW,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic seed_init;
        logic seed_mul;
        logic seed_wr;
        logic draw_tw;
        logic keep;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_start;
        logic pos_zero;
        logic widx_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & UpperMask) | (nxt & LowerMask);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ MatrixA;
        end
        return v;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== design/mbsc_in_if.sv =====
// Input channel of the cipher: data byte and message start flag.
// No dependencies.
`timescale 1ns / 1ps
interface mbsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

// ===== design/mbsc_out_if.sv =====
// Output channel of the cipher: one result byte per transfer.
// No dependencies.
`timescale 1ns / 1ps
interface mbsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== design/mbsc_ctrl.sv =====
// Controller state machine: sequences reseeding, word draws and result hand-off.
// Depends on mbsc_pkg.
`timescale 1ns / 1ps
module mbsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbsc_pkg::t_dp_sts i_sts,
    output mbsc_pkg::t_dp_cmd o_cmd
);

    mbsc_pkg::t_state r_state, n_state;
    logic             r_discard, n_discard;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mbsc_pkg::ST_IDLE;
            r_discard <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_discard <= n_discard;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_discard = r_discard;
        o_cmd     = '0;
        unique case (r_state)
            mbsc_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_start) begin
                        n_state = mbsc_pkg::ST_SEED_INIT;
                    end else begin
                        n_state   = mbsc_pkg::ST_DRAW_RD;
                        n_discard = i_sts.pos_zero;
                    end
                end
            end
            mbsc_pkg::ST_SEED_INIT: begin
                o_cmd.seed_init = 1'b1;
                n_state         = mbsc_pkg::ST_SEED_MUL;
            end
            mbsc_pkg::ST_SEED_MUL: begin
                o_cmd.seed_mul = 1'b1;
                n_state        = mbsc_pkg::ST_SEED_WR;
            end
            mbsc_pkg::ST_SEED_WR: begin
                o_cmd.seed_wr = 1'b1;
                if (i_sts.widx_last) begin
                    n_state   = mbsc_pkg::ST_DRAW_RD;
                    n_discard = 1'b1;
                end else begin
                    n_state = mbsc_pkg::ST_SEED_MUL;
                end
            end
            mbsc_pkg::ST_DRAW_RD: begin
                n_state = mbsc_pkg::ST_DRAW_TW;
            end
            mbsc_pkg::ST_DRAW_TW: begin
                o_cmd.draw_tw = 1'b1;
                o_cmd.keep    = !r_discard;
                if (r_discard) begin
                    n_discard = 1'b0;
                    n_state   = mbsc_pkg::ST_DRAW_RD;
                end else begin
                    n_state = mbsc_pkg::ST_OUT;
                end
            end
            mbsc_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mbsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mbsc_dp.sv =====
// Datapath: generator word memory, seeding multiplier, lazy twist, tempering,
// byte select and output register. Depends on mbsc_pkg and the channel interfaces.
`timescale 1ns / 1ps
module mbsc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbsc_pkg::t_dp_cmd i_cmd,
    output mbsc_pkg::t_dp_sts o_sts,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    mbsc_in_if.sink           i_in,
    mbsc_out_if.source        o_out
);

    logic [31:0]                 r_mem [mbsc_pkg::WordCount];
    logic [15:0]                 r_seed;
    logic [mbsc_pkg::IdxW-1:0]   r_widx;
    logic [1:0]                  r_pos;
    logic [7:0]                  r_data;
    logic [31:0]                 r_cur;
    logic [31:0]                 r_p;
    logic [31:0]                 r_prod;
    logic [31:0]                 r_rd_nxt;
    logic [31:0]                 r_rd_far;
    logic [7:0]                  r_res;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;

    logic                        w_accept;
    logic [mbsc_pkg::IdxW-1:0]   w_addr_nxt;
    logic [mbsc_pkg::IdxW-1:0]   w_addr_far;
    logic [mbsc_pkg::IdxW-1:0]   w_idx_inc;
    logic [31:0]                 w_twisted;
    logic [31:0]                 w_tempered;
    logic [31:0]                 w_seed_word;
    logic                        w_we;
    logic [mbsc_pkg::IdxW-1:0]   w_waddr;
    logic [31:0]                 w_wdata;

    assign w_accept   = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;

    assign w_idx_inc  = (r_widx == mbsc_pkg::IdxLast) ? '0 : mbsc_pkg::IdxW'(r_widx + 1'b1);
    assign w_addr_nxt = w_idx_inc;
    assign w_addr_far = (r_widx >= mbsc_pkg::ShiftBck) ?
                        mbsc_pkg::IdxW'(r_widx - mbsc_pkg::ShiftBck) :
                        mbsc_pkg::IdxW'(r_widx + mbsc_pkg::ShiftFwd);

    assign w_twisted   = mbsc_pkg::twist_word(r_cur, r_rd_nxt, r_rd_far);
    assign w_tempered  = mbsc_pkg::temper(w_twisted);
    assign w_seed_word = 32'(r_prod + {{(32 - mbsc_pkg::IdxW){1'b0}}, r_widx});

    always_comb begin
        w_we    = i_cmd.seed_init || i_cmd.seed_wr || i_cmd.draw_tw;
        w_waddr = r_widx;
        w_wdata = w_twisted;
        if (i_cmd.seed_init) begin
            w_waddr = '0;
            w_wdata = {16'h0000, r_seed};
        end else if (i_cmd.seed_wr) begin
            w_wdata = w_seed_word;
        end
    end

    // word memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_nxt <= r_mem[w_addr_nxt];
        r_rd_far <= r_mem[w_addr_far];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_widx      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (w_accept && i_in.message_start) begin
                r_pos <= '0;
            end else if (i_cmd.draw_tw && i_cmd.keep) begin
                r_pos <= 2'(r_pos + 1'b1);
            end
            if (i_cmd.seed_init) begin
                r_widx <= mbsc_pkg::IdxW'(1);
            end else if (i_cmd.seed_wr || i_cmd.draw_tw) begin
                r_widx <= w_idx_inc;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_in.data_byte;
        end
        if (i_cmd.seed_init) begin
            r_p   <= {16'h0000, r_seed};
            r_cur <= {16'h0000, r_seed};
        end else if (i_cmd.draw_tw) begin
            r_cur <= r_rd_nxt;
        end
        if (i_cmd.seed_wr) begin
            r_p <= w_seed_word;
        end
        if (i_cmd.seed_mul) begin
            r_prod <= 32'(mbsc_pkg::InitMult * (r_p ^ (r_p >> 30)));
        end
        if (i_cmd.draw_tw && i_cmd.keep) begin
            r_res <= r_data ^ 8'(w_tempered >> {r_pos, 3'b000});
        end
        if (i_cmd.load_out) begin
            r_out_byte <= r_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.in_start  = i_in.message_start;
    assign o_sts.pos_zero  = (r_pos == 2'd0);
    assign o_sts.widx_last = (r_widx == mbsc_pkg::IdxLast);
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

endmodule

// ===== design/mt19937_byte_stream_cipher.sv =====
// MT19937 byte stream cipher, top level. One byte per transfer; one generator word is
// twisted per draw (memory read, then twist and write back).
// A byte at position 0 takes an extra draw whose word is discarded; a message start
// first reseeds the word memory (each word through the seeding multiplier). Synchronous
// active-low reset clears control state and the seed register; the word memory is not
// cleared.
`timescale 1ns / 1ps
`include "mt19937_byte_stream_cipher_defines.svh"
module mt19937_byte_stream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    mbsc_in_if.sink     i_in,
    mbsc_out_if.source  o_out
);

    mbsc_pkg::t_dp_cmd w_cmd;
    mbsc_pkg::t_dp_sts w_sts;

    mbsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mbsc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    `MBSC_ASSERT_NEXT(a_accept_drops_ready, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `MBSC_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in.valid && i_in.ready, !w_cmd.load_out)
    `MBSC_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, w_cmd.load_out, w_sts.out_free)
    `MBSC_ASSERT_SAME(a_one_writer, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.seed_init, w_cmd.seed_wr, w_cmd.draw_tw}))

endmodule

// ===== test/tb_top.sv =====
// Testbench for the MT19937 byte stream cipher: a keystream predictor checks every output byte.
// Depends on mbsc_in_if, mbsc_out_if and mt19937_byte_stream_cipher.
`timescale 1ns / 1ps
module tb_top;

    localparam int unsigned MT_N      = 624;
    localparam int unsigned MT_M      = 397;
    localparam logic [31:0] TWIST_XOR = 32'h9908_B0DF;
    localparam logic [31:0] HI_BIT    = 32'h8000_0000;
    localparam logic [31:0] LO_BITS   = 32'h7FFF_FFFF;
    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;

    class keystream_scoreboard;
        logic [31:0]   words [MT_N];
        int unsigned   word_idx;
        logic [1:0]    byte_pos;
        logic [15:0]   seed;
        logic [7:0]    due_bytes [$];
        int unsigned   fail_count;

        function new();
            word_idx   = MT_N;
            byte_pos   = 2'd0;
            seed       = 16'd0;
            fail_count = 0;
        endfunction

        function void set_seed(input logic [15:0] s);
            seed = s;
        endfunction

        function void load_seed();
            int unsigned i;
            logic [31:0] prev;
            words[0] = {16'd0, seed};
            for (i = 1; i < MT_N; i++) begin
                prev     = words[i - 1];
                words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
            end
            word_idx = MT_N;
        endfunction

        function void regenerate();
            int unsigned i;
            logic [31:0] mix;
            logic [31:0] nxt;
            for (i = 0; i < MT_N; i++) begin
                mix = (words[i] & HI_BIT) | (words[(i + 1) % MT_N] & LO_BITS);
                nxt = words[(i + MT_M) % MT_N] ^ (mix >> 1);
                if (mix[0]) begin
                    nxt = nxt ^ TWIST_XOR;
                end
                words[i] = nxt;
            end
            word_idx = 0;
        endfunction

        function logic [31:0] next_word();
            logic [31:0] w;
            if (word_idx >= MT_N) begin
                regenerate();
            end
            w = words[word_idx];
            word_idx++;
            w = w ^ (w >> 11);
            w = w ^ ((w << 7) & TEMPER_B);
            w = w ^ ((w << 15) & TEMPER_C);
            w = w ^ (w >> 18);
            return w;
        endfunction

        function void note_input(input logic [7:0] data, input logic start);
            logic [31:0] ks;
            if (start) begin
                load_seed();
                byte_pos = 2'd0;
            end
            if (byte_pos == 2'd0) begin
                ks = next_word();
            end
            ks = next_word();
            due_bytes = {due_bytes, 8'(data ^ 8'(ks >> {byte_pos, 3'b000}))};
            byte_pos = byte_pos + 2'd1;
        endfunction

        function void check_result(input logic [7:0] actual);
            logic [7:0] want;
            if (due_bytes.size() == 0) begin
                $error("out_byte %02h arrived with no input outstanding", actual);
                fail_count++;
            end else begin
                want = due_bytes.pop_front();
                if (actual !== want) begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want, actual);
                    fail_count++;
                end
            end
        endfunction

        function int unsigned pending();
            return due_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_len;

    keystream_scoreboard scoreboard;

    mbsc_in_if  in_if ();
    mbsc_out_if out_if ();

    mt19937_byte_stream_cipher i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial begin
        #16_000_000;
        $display("simulation failed");
        $finish;
    end

    // sink side: check each transfer, then decide ready for the next edge
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
                scoreboard.check_result(out_if.out_byte);
            end
            if (hold_off_len > 0) begin
                out_if.ready <= 1'b0;
                hold_off_len--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic start);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid         <= 1'b0;
            in_if.data_byte     <= 8'($urandom);
            in_if.message_start <= 1'($urandom);
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= data;
        in_if.message_start <= start;
        do @(posedge clk); while (!in_if.ready);
        scoreboard.note_input(data, start);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (scoreboard.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [15:0] s);
        cfg_we   <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        scoreboard.set_seed(s);
    endtask

    task automatic send_message(input int unsigned len, input logic with_start);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            send_byte(8'($urandom), with_start && (i == 0));
        end
    endtask

    task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                             input logic [15:0] s, input int unsigned count);
        int unsigned sent;
        int unsigned len;
        bit          held;
        bit          paused;
        drain();
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        write_seed(s);
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(120, 25);
            end else begin
                len = $urandom_range(24, 1);
            end
            // the first message of a phase always reseeds; later ones sometimes carry on
            send_message(len, (sent == 0) || ($urandom_range(9) != 0));
            sent += len;
            if (!held && sent > count / 3) begin
                hold_off_len = 400;
                held         = 1'b1;
            end
            if (!paused && sent > (2 * count) / 3) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        scoreboard = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_len   = 0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= 16'd0;
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= 8'd0;
        in_if.message_start <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seed left at its reset value; walk every byte position and wrap
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // restart part way through a word
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        drain();
        // new message without a start flag carries on from the current state
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        drain();
        write_seed(16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b1);
        send_byte(8'h56, 1'b0);
        drain();
        write_seed(16'h0000);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b0);

        run_phase(0, 0, 16'($urandom), 225);
        run_phase(84, 0, 16'h0000, 225);
        run_phase(0, 84, 16'($urandom), 225);
        run_phase(13, 13, 16'h0001, 225);

        drain();
        repeat (20) @(posedge clk);
        if (scoreboard.fail_count == 0 && scoreboard.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
